/* rtl/ppm4_pkg.sv */
package ppm4_pkg;

  localparam int unsigned FRAME_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int unsigned BP_W        = 9;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2
  } cmd_e;

  typedef enum logic {
    CFG_FRAME_LENGTH = 1'b0,
    CFG_REPEAT_COUNT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic ir_burst;
    logic busy_res;
    logic done_res;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  localparam logic [10:0] BURST_TICKS = 11'd3;
  localparam logic [10:0] PAUSE_TICKS = 11'd2000;
  localparam logic [10:0] ERR_LIMIT   = 11'd1000;
  // err_q never reaches this: below the limit after the subtract, plus the largest step
  localparam logic [10:0] ERR_BOUND   = 11'd1414;

  localparam logic [10:0] GAP_TICKS [4] = '{11'd5, 11'd23, 11'd11, 11'd17};
  localparam logic [10:0] GAP_ERROR [4] = '{11'd103, 11'd414, 11'd207, 11'd310};

endpackage

/* rtl/ppm4_store.sv */
module ppm4_store (
  input  logic                  clk_i,
  input  ppm4_pkg::store_req_t  req_i,
  output logic [7:0]            rd_data_o
);

  logic [7:0] mem_q [ppm4_pkg::FRAME_DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // forward a write to the address being read so the byte is always current
  always_ff @(posedge clk_i) begin
    if (req_i.we && (req_i.waddr == req_i.raddr)) begin
      rd_q <= req_i.wdata;
    end else begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* rtl/ppm4_seq.sv */
module ppm4_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  ppm4_pkg::in_item_t    item_i,
  input  logic [7:0]            frame_length_i,
  input  logic [7:0]            repeat_count_i,
  input  logic [7:0]            rd_data_i,
  output ppm4_pkg::store_req_t  store_req_o,
  output ppm4_pkg::out_item_t   result_o
);

  logic                      active_q, active_d;
  logic [10:0]               ticks_q, ticks_d;
  logic                      burst_q, burst_d;
  logic [7:0]                shift_q, shift_d;
  logic [1:0]                sym_q, sym_d;
  logic [1:0]                phase_q, phase_d;
  logic [ppm4_pkg::BP_W-1:0] bp_q, bp_d;
  logic [7:0]                reps_q, reps_d;
  logic [10:0]               err_q, err_d;
  logic [7:0]                taken_q, taken_d;
  logic                      done;
  logic [ppm4_pkg::ADDR_W+ppm4_pkg::BP_W-1:0] raddr_pad;
  logic [ppm4_pkg::ADDR_W+7:0]                waddr_pad;

  always_comb begin
    logic [7:0]  byte_v;
    logic [10:0] gap_v;
    logic [10:0] err_v;
    active_d = active_q;
    ticks_d  = ticks_q;
    burst_d  = burst_q;
    shift_d  = shift_q;
    sym_d    = sym_q;
    phase_d  = phase_q;
    bp_d     = bp_q;
    reps_d   = reps_q;
    err_d    = err_q;
    taken_d  = taken_q;
    done     = 1'b0;
    byte_v   = (phase_q == 2'd0) ? rd_data_i : shift_q;
    gap_v    = ppm4_pkg::GAP_TICKS[sym_q];
    err_v    = err_q;
    if (err_q >= ppm4_pkg::ERR_LIMIT) begin
      gap_v = gap_v + 11'd1;
      err_v = err_q - ppm4_pkg::ERR_LIMIT;
    end
    err_v = err_v + ppm4_pkg::GAP_ERROR[sym_q];

    if (accept_i) begin
      unique case (item_i.command)
        ppm4_pkg::CMD_TICK: begin
          if (active_q) begin
            if (ticks_q != 11'd0) begin
              ticks_d = ticks_q - 11'd1;
            end else if (!burst_q) begin
              burst_d = 1'b1;
              ticks_d = ppm4_pkg::BURST_TICKS;
              if (phase_q == 2'd0) begin
                bp_d = bp_q + {{(ppm4_pkg::BP_W-1){1'b0}}, 1'b1};
              end
              sym_d   = byte_v[1:0];
              shift_d = {2'b00, byte_v[7:2]};
              phase_d = phase_q + 2'd1;
            end else begin
              burst_d = 1'b0;
              ticks_d = gap_v;
              err_d   = err_v;
              // past the last byte: the terminating burst has just ended
              if (bp_q > {1'b0, taken_q}) begin
                if (reps_q != 8'd0) begin
                  reps_d  = reps_q - 8'd1;
                  bp_d    = '0;
                  phase_d = 2'd0;
                  err_d   = 11'd0;
                  ticks_d = ppm4_pkg::PAUSE_TICKS;
                end else begin
                  active_d = 1'b0;
                  done     = 1'b1;
                end
              end
            end
          end
        end
        ppm4_pkg::CMD_WRITE: begin
        end
        ppm4_pkg::CMD_START: begin
          taken_d  = frame_length_i;
          reps_d   = repeat_count_i;
          bp_d     = '0;
          ticks_d  = 11'd0;
          burst_d  = 1'b0;
          phase_d  = 2'd0;
          err_d    = 11'd0;
          active_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ticks_q  <= 11'd0;
      burst_q  <= 1'b0;
      shift_q  <= 8'd0;
      sym_q    <= 2'd0;
      phase_q  <= 2'd0;
      bp_q     <= '0;
      reps_q   <= 8'd0;
      err_q    <= 11'd0;
      taken_q  <= 8'd0;
    end else begin
      active_q <= active_d;
      ticks_q  <= ticks_d;
      burst_q  <= burst_d;
      shift_q  <= shift_d;
      sym_q    <= sym_d;
      phase_q  <= phase_d;
      bp_q     <= bp_d;
      reps_q   <= reps_d;
      err_q    <= err_d;
      taken_q  <= taken_d;
    end
  end

  // read the next byte continuously so it is ready when the burst starts
  assign raddr_pad = {{ppm4_pkg::ADDR_W{1'b0}}, bp_d};
  assign waddr_pad = {{ppm4_pkg::ADDR_W{1'b0}}, item_i.byte_index};

  assign store_req_o.we    = accept_i && (item_i.command == ppm4_pkg::CMD_WRITE);
  assign store_req_o.waddr = waddr_pad[ppm4_pkg::ADDR_W-1:0];
  assign store_req_o.wdata = item_i.byte_value;
  assign store_req_o.raddr = raddr_pad[ppm4_pkg::ADDR_W-1:0];

  assign result_o.ir_burst = burst_d;
  assign result_o.busy_res = active_d;
  assign result_o.done_res = done;

  a_burst_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> active_q)
    else $error("burst on while idle");

  a_ticks_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ticks_q <= ppm4_pkg::PAUSE_TICKS)
    else $error("tick counter beyond pause length");

  a_err_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q < ppm4_pkg::ERR_BOUND)
    else $error("error accumulator out of range");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !active_q && !burst_q)
    else $error("transmission still running after finish");

endmodule

/* rtl/ppm4_ir_frame_transmitter.sv */
// IR pulse-position envelope transmitter.
// Input channel (in_valid_i/in_ready_o, in_item_i) carries one command per item:
// a tick advances the envelope by one step, a write stores byte_value at
// byte_index in the frame store, a start arms a transmission using the
// frame_length and repeat_count registers as they stand at that moment.
// Every accepted item yields exactly one result item on the output channel
// (out_valid_o/out_ready_i, out_item_o): envelope level, busy and done flags.
// The result is registered and valid in the cycle after acceptance.
// Throughput is one item per cycle unless a held result stalls the input;
// the whole state update is a single registered pass, and the frame store
// is read ahead from its synchronous port with write forwarding.
// When the receiver stalls, the pending result holds and in_ready_o stays
// low until it is taken; the input is accepted in the same cycle as the
// held result leaves.
// Reset clears all control state and both registers; no clearing pass is
// run, and the frame store holds unknown bytes until written.
// Configuration (cfg_valid_i, cfg_index_i, cfg_data_i) is always ready.
module ppm4_ir_frame_transmitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ppm4_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ppm4_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  ppm4_pkg::cfg_idx_e   cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  logic                 accept;
  logic [7:0]           frame_length_q;
  logic [7:0]           repeat_count_q;
  logic                 out_valid_q, out_valid_d;
  ppm4_pkg::out_item_t  out_item_q;
  ppm4_pkg::out_item_t  result;
  ppm4_pkg::store_req_t store_req;
  logic [7:0]           rd_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q <= 8'd0;
      repeat_count_q <= 8'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppm4_pkg::CFG_FRAME_LENGTH: frame_length_q <= cfg_data_i;
        ppm4_pkg::CFG_REPEAT_COUNT: repeat_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  ppm4_store u_store (
    .clk_i     (clk_i),
    .req_i     (store_req),
    .rd_data_o (rd_data)
  );

  ppm4_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (in_item_i),
    .frame_length_i (frame_length_q),
    .repeat_count_i (repeat_count_q),
    .rd_data_i      (rd_data),
    .store_req_o    (store_req),
    .result_o       (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res && !out_item_o.ir_burst)
    else $error("finish reported while still transmitting");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item produced no result");

endmodule
